[hw/rtl/hse_pkg.sv]
`default_nettype none
package hse_pkg;

  localparam int BIN_COUNT_DEF = 1024;

  localparam int VALUE_W = 10;
  localparam int FRAC_W = 17;
  localparam int CNT_W = 32;
  localparam int SUM_W = 48;
  localparam int MEAN_W = 18;
  localparam int SHARE_W = 17;
  localparam int QUO_W = 18;
  localparam int NUM_W = 56;

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 144;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

endpackage
`default_nettype wire

[hw/rtl/histogram_stats_engine.sv]
`default_nettype none
// Histogram statistics engine. Bin counts live in one synchronous memory of BIN_COUNT
// 32-bit words. An add transfer is taken every cycle while idle: the bin is read when
// the add is accepted and written back in the following cycle, with the last write
// forwarded when two adds hit the same bin. A report walks all bins through the memory
// read port, then a shared one-bit-per-cycle divider forms the mean and the three shares
// (skipped when the histogram is empty); the result waits until the output register is
// free, then stays there while new transfers are accepted. A clear, and the clearing
// pass after reset, write one bin per cycle over all BIN_COUNT bins, accepting no transfer.
module histogram_stats_engine #(
  parameter int BIN_COUNT = hse_pkg::BIN_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // sample_value [9:0], fraction_q16 [26:10], zero [31:27]
  input  wire logic [hse_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind [1:0]
  input  wire logic [1:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // total_count [31:0], mean_q8 [49:32], first_value [59:50], first_share_q16 [76:60],
  // second_value [86:77], second_share_q16 [103:87], third_value [113:104],
  // third_share_q16 [130:114], percentile_value [140:131], zero [143:141]
  output logic [hse_pkg::OUT_DATA_W-1:0]      out_tdata,
  // error [0]
  output logic [0:0]                          out_tuser
);

  localparam int IW = $clog2(BIN_COUNT);
  localparam logic [IW-1:0] LAST_BIN = IW'(BIN_COUNT - 1);
  localparam int CW = hse_pkg::CNT_W;
  localparam int QW = hse_pkg::QUO_W;
  localparam int NW = hse_pkg::NUM_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t state_r;

  logic [CW-1:0] bin_mem [BIN_COUNT];
  logic [CW-1:0] rd_data_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;

  logic [IW-1:0] clr_idx_r;
  logic          s1_valid_r;
  logic [IW-1:0] s1_addr_r;
  logic          last_valid_r;
  logic [IW-1:0] last_addr_r;
  logic [CW-1:0] last_data_r;
  logic [CW-1:0] total_r;
  logic [hse_pkg::SUM_W-1:0] sum_r;

  logic [IW-1:0] walk_idx_r;
  logic          issue_done_r;
  logic          pv_valid_r;
  logic [IW-1:0] pv_idx_r;
  logic [CW-1:0] top_cnt_r [3];
  logic [hse_pkg::VALUE_W-1:0] top_val_r [3];
  logic [CW-1:0] cum_r;
  logic          found_r;
  logic [hse_pkg::VALUE_W-1:0] pval_r;
  logic [48:0]   limit_r;

  logic [1:0]    div_sel_r;
  logic [4:0]    div_step_r;
  logic          div_load_r;
  logic [CW-1:0] rem_r;
  logic [QW-1:0] nlow_r;
  logic [QW-1:0] quo_r;
  logic [hse_pkg::MEAN_W-1:0]  mean_r;
  logic [hse_pkg::SHARE_W-1:0] share_r [3];

  logic          out_valid_r;
  logic [hse_pkg::OUT_DATA_W-1:0] out_data_r;
  logic          out_err_r;

  logic          in_acc;
  logic [1:0]    in_kind;
  logic [hse_pkg::VALUE_W-1:0] in_value;
  logic [hse_pkg::FRAC_W-1:0]  in_frac;
  logic          add_ok;
  logic [CW-1:0] cum_nxt;
  logic          hit_nxt;
  logic [NW-1:0] div_num;
  logic [CW:0]   trial;
  logic          trial_ge;
  logic [CW:0]   trial_diff;
  logic [QW-1:0] quo_nxt;
  logic          out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign in_kind = in_tuser;
  assign in_value = in_tdata[9:0];
  assign in_frac = in_tdata[26:10];
  assign add_ok = in_acc && (in_kind == hse_pkg::KIND_ADD)
                  && ({22'd0, in_value} < 32'(BIN_COUNT)) && (total_r != '1);

  assign mem_we = (state_r == ST_CLEAR) || s1_valid_r;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : s1_addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 :
                     (((last_valid_r && (last_addr_r == s1_addr_r)) ? last_data_r : rd_data_r)
                      + 32'd1);
  assign mem_re = add_ok || ((state_r == ST_WALK) && !issue_done_r);
  assign mem_raddr = (state_r == ST_WALK) ? walk_idx_r : IW'(in_value);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= bin_mem[mem_raddr];
    end
  end

  assign cum_nxt = cum_r + rd_data_r;
  assign hit_nxt = ({1'b0, cum_nxt, 16'd0} > limit_r);

  always_comb begin
    case (div_sel_r)
      2'd0: div_num = {sum_r, 8'd0};
      2'd1: div_num = {8'd0, top_cnt_r[0], 16'd0};
      2'd2: div_num = {8'd0, top_cnt_r[1], 16'd0};
      default: div_num = {8'd0, top_cnt_r[2], 16'd0};
    endcase
  end

  assign trial = {rem_r, nlow_r[QW-1]};
  assign trial_ge = (trial >= {1'b0, total_r});
  assign trial_diff = trial - {1'b0, total_r};
  assign quo_nxt = {quo_r[QW-2:0], trial_ge};
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_idx_r <= '0;
      s1_valid_r <= 1'b0;
      last_valid_r <= 1'b0;
      total_r <= '0;
      sum_r <= '0;
      out_valid_r <= 1'b0;
      issue_done_r <= 1'b0;
      pv_valid_r <= 1'b0;
      div_load_r <= 1'b0;
    end else begin
      s1_valid_r <= add_ok;
      s1_addr_r <= IW'(in_value);
      last_valid_r <= s1_valid_r;
      last_addr_r <= s1_addr_r;
      last_data_r <= mem_wdata;
      pv_valid_r <= (state_r == ST_WALK) && !issue_done_r;
      pv_idx_r <= walk_idx_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_BIN) begin
            total_r <= '0;
            sum_r <= '0;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (add_ok) begin
            total_r <= total_r + 32'd1;
            sum_r <= sum_r + {38'd0, in_value};
          end
          if (in_acc && (in_kind == hse_pkg::KIND_CLEAR)) begin
            clr_idx_r <= '0;
            state_r <= ST_CLEAR;
          end
          if (in_acc && (in_kind == hse_pkg::KIND_REPORT)) begin
            walk_idx_r <= '0;
            issue_done_r <= 1'b0;
            cum_r <= '0;
            found_r <= 1'b0;
            pval_r <= '0;
            limit_r <= 49'(in_frac) * 49'(total_r);
            for (int k = 0; k < 3; k++) begin
              top_cnt_r[k] <= '0;
              top_val_r[k] <= '0;
            end
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!issue_done_r) begin
            walk_idx_r <= walk_idx_r + 1'b1;
            if (walk_idx_r == LAST_BIN) begin
              issue_done_r <= 1'b1;
            end
          end
          if (pv_valid_r) begin
            cum_r <= cum_nxt;
            if (!found_r && (total_r != '0) && hit_nxt) begin
              found_r <= 1'b1;
              pval_r <= hse_pkg::VALUE_W'(pv_idx_r);
            end
            if (rd_data_r > top_cnt_r[0]) begin
              top_cnt_r[2] <= top_cnt_r[1];
              top_val_r[2] <= top_val_r[1];
              top_cnt_r[1] <= top_cnt_r[0];
              top_val_r[1] <= top_val_r[0];
              top_cnt_r[0] <= rd_data_r;
              top_val_r[0] <= hse_pkg::VALUE_W'(pv_idx_r);
            end else if (rd_data_r > top_cnt_r[1]) begin
              top_cnt_r[2] <= top_cnt_r[1];
              top_val_r[2] <= top_val_r[1];
              top_cnt_r[1] <= rd_data_r;
              top_val_r[1] <= hse_pkg::VALUE_W'(pv_idx_r);
            end else if (rd_data_r > top_cnt_r[2]) begin
              top_cnt_r[2] <= rd_data_r;
              top_val_r[2] <= hse_pkg::VALUE_W'(pv_idx_r);
            end
            if (pv_idx_r == LAST_BIN) begin
              if (total_r == '0) begin
                mean_r <= '0;
                for (int k = 0; k < 3; k++) begin
                  share_r[k] <= '0;
                end
                state_r <= ST_HOLD;
              end else begin
                div_sel_r <= 2'd0;
                div_load_r <= 1'b1;
                state_r <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_load_r) begin
            rem_r <= div_num[QW+CW-1:QW];
            nlow_r <= div_num[QW-1:0];
            quo_r <= '0;
            div_step_r <= '0;
            div_load_r <= 1'b0;
          end else begin
            rem_r <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
            nlow_r <= {nlow_r[QW-2:0], 1'b0};
            quo_r <= quo_nxt;
            div_step_r <= div_step_r + 5'd1;
            if (div_step_r == 5'(QW - 1)) begin
              case (div_sel_r)
                2'd0: mean_r <= quo_nxt;
                2'd1: share_r[0] <= quo_nxt[hse_pkg::SHARE_W-1:0];
                2'd2: share_r[1] <= quo_nxt[hse_pkg::SHARE_W-1:0];
                default: share_r[2] <= quo_nxt[hse_pkg::SHARE_W-1:0];
              endcase
              div_load_r <= (div_sel_r != 2'd3);
              div_sel_r <= div_sel_r + 2'd1;
              if (div_sel_r == 2'd3) begin
                state_r <= ST_HOLD;
              end
            end
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          clr_idx_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'd0, (found_r ? pval_r : 10'd0),
                     share_r[2], top_val_r[2], share_r[1], top_val_r[1],
                     share_r[0], top_val_r[0], mean_r, total_r};
      out_err_r <= !found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_err_r;

`ifndef NO_ASSERTIONS
  a_cum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cum_r <= total_r))
    else $error("cumulative count exceeds total");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    add_ok |=> (total_r == $past(total_r) + 32'd1))
    else $error("accepted add did not bump total");

  a_write_follows_add: assert property (@(posedge clk) disable iff (!rst_n)
    add_ok |=> (s1_valid_r && mem_we))
    else $error("accepted add not written back");

  a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && !div_load_r) |-> (div_step_r < 5'(QW)))
    else $error("divider step out of range");
`endif

endmodule
`default_nettype wire

[test/tb_histogram_stats_engine.sv]
`default_nettype none
module tb_histogram_stats_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = hse_pkg::BIN_COUNT_DEF;
  localparam int N_RANDOM = 730;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic                          err;
    logic [2:0]                    pad;
    logic [hse_pkg::VALUE_W-1:0]   pct_value;
    logic [hse_pkg::SHARE_W-1:0]   third_share;
    logic [hse_pkg::VALUE_W-1:0]   third_value;
    logic [hse_pkg::SHARE_W-1:0]   second_share;
    logic [hse_pkg::VALUE_W-1:0]   second_value;
    logic [hse_pkg::SHARE_W-1:0]   first_share;
    logic [hse_pkg::VALUE_W-1:0]   first_value;
    logic [hse_pkg::MEAN_W-1:0]    mean;
    logic [hse_pkg::CNT_W-1:0]     total;
  } report_t;

  typedef struct {
    logic [1:0]                  kind;
    logic [hse_pkg::VALUE_W-1:0] value;
    logic [hse_pkg::FRAC_W-1:0]  frac;
    bit                          typed;
    report_t                     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hse_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hse_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  histogram_stats_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [hse_pkg::CNT_W-1:0] hist_bins [NBINS];
  logic [hse_pkg::CNT_W-1:0] hist_total;
  logic [hse_pkg::SUM_W-1:0] hist_sum;
  report_t pending_reports [$];
  row_t rows [$];
  bit failed = 1'b0;
  longint cycles = 0;

  function automatic report_t make_report(logic [31:0] total, logic [17:0] mean,
      logic [9:0] fv, logic [16:0] fs, logic [9:0] sv, logic [16:0] ss,
      logic [9:0] tv, logic [16:0] ts, logic [9:0] pct, logic err);
    report_t r;
    r = '0;
    r.total = total; r.mean = mean;
    r.first_value = fv; r.first_share = fs;
    r.second_value = sv; r.second_share = ss;
    r.third_value = tv; r.third_share = ts;
    r.pct_value = pct; r.err = err;
    return r;
  endfunction

  function automatic logic [hse_pkg::SHARE_W-1:0] share_of(logic [31:0] cnt);
    logic [63:0] q;
    q = ({32'd0, cnt} << 16) / {32'd0, hist_total};
    return (hist_total == 0) ? '0 : q[hse_pkg::SHARE_W-1:0];
  endfunction

  function automatic report_t predict_report(logic [hse_pkg::FRAC_W-1:0] frac);
    report_t r;
    logic [31:0] top_cnt [3];
    logic [9:0] top_val [3];
    logic [63:0] cum;
    logic [63:0] bound;
    logic [63:0] mq;
    bit found;
    r = '0;
    cum = 0;
    found = 0;
    bound = {47'd0, frac} * {32'd0, hist_total};
    for (int k = 0; k < 3; k++) begin
      top_cnt[k] = 0;
      top_val[k] = 0;
    end
    for (int v = 0; v < NBINS; v++) begin
      logic [31:0] c;
      c = hist_bins[v];
      if (c != 0) begin
        if (c > top_cnt[0]) begin
          top_cnt[2] = top_cnt[1]; top_val[2] = top_val[1];
          top_cnt[1] = top_cnt[0]; top_val[1] = top_val[0];
          top_cnt[0] = c; top_val[0] = v;
        end else if (c > top_cnt[1]) begin
          top_cnt[2] = top_cnt[1]; top_val[2] = top_val[1];
          top_cnt[1] = c; top_val[1] = v;
        end else if (c > top_cnt[2]) begin
          top_cnt[2] = c; top_val[2] = v;
        end
      end
      cum = cum + c;
      if (!found && hist_total != 0 && (cum << 16) > bound) begin
        found = 1;
        r.pct_value = v;
      end
    end
    r.total = hist_total;
    mq = (hist_total == 0) ? 64'd0 : ({16'd0, hist_sum} << 8) / {32'd0, hist_total};
    r.mean = mq[hse_pkg::MEAN_W-1:0];
    r.first_value = top_val[0]; r.first_share = share_of(top_cnt[0]);
    r.second_value = top_val[1]; r.second_share = share_of(top_cnt[1]);
    r.third_value = top_val[2]; r.third_share = share_of(top_cnt[2]);
    r.err = !found;
    return r;
  endfunction

  task automatic clear_hist();
    for (int v = 0; v < NBINS; v++) hist_bins[v] = '0;
    hist_total = '0;
    hist_sum = '0;
  endtask

  task automatic add_row(logic [1:0] kind, logic [9:0] value, logic [16:0] frac,
      bit typed = 0, report_t want = '0);
    row_t r;
    r.kind = kind; r.value = value; r.frac = frac; r.typed = typed; r.want = want;
    rows = {rows, r};
  endtask

  task automatic send_item(row_t r);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {5'd0, r.frac, r.value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (r.kind)
      hse_pkg::KIND_ADD: begin
        if (hist_total != 32'hFFFF_FFFF) begin
          hist_bins[r.value] = hist_bins[r.value] + 1;
          hist_total = hist_total + 1;
          hist_sum = hist_sum + r.value;
        end
      end
      hse_pkg::KIND_REPORT:
        pending_reports = {pending_reports, (r.typed ? r.want : predict_report(r.frac))};
      hse_pkg::KIND_CLEAR: clear_hist();
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_reports.pop_front();
        check_field("total_count", want.total, got.total);
        check_field("mean_q8", want.mean, got.mean);
        check_field("first_value", want.first_value, got.first_value);
        check_field("first_share_q16", want.first_share, got.first_share);
        check_field("second_value", want.second_value, got.second_value);
        check_field("second_share_q16", want.second_share, got.second_share);
        check_field("third_value", want.third_value, got.third_value);
        check_field("third_share_q16", want.third_share, got.third_share);
        check_field("percentile_value", want.pct_value, got.pct_value);
        check_field("error", want.err, got.err);
      end
    end
  end

  int stall_left = 0;
  bit stall_free = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) stall_free <= !stall_free;
    if (stall_free) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    report_t four;
    report_t empty;
    row_t r;
    int narrow;
    int pick;
    clear_hist();
    empty = make_report(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    four = make_report(4, 131264, 1023, 32768, 0, 16384, 5, 16384, 0, 1);
    add_row(hse_pkg::KIND_REPORT, 0, 0, 1, empty);
    add_row(hse_pkg::KIND_ADD, 0, 0);
    add_row(hse_pkg::KIND_ADD, 1023, 0);
    add_row(hse_pkg::KIND_ADD, 1023, 131071);
    add_row(hse_pkg::KIND_ADD, 5, 0);
    add_row(KIND_UNUSED, 7, 131071);
    add_row(hse_pkg::KIND_REPORT, 0, 65536, 1, four);
    add_row(hse_pkg::KIND_REPORT, 1023, 131071, 1, four);
    add_row(hse_pkg::KIND_REPORT, 0, 0);
    add_row(hse_pkg::KIND_REPORT, 0, 65535);
    add_row(hse_pkg::KIND_CLEAR, 0, 0);
    add_row(hse_pkg::KIND_REPORT, 0, 0, 1, empty);
    add_row(hse_pkg::KIND_ADD, 3, 0);
    add_row(hse_pkg::KIND_ADD, 7, 0);
    add_row(hse_pkg::KIND_ADD, 3, 0);
    add_row(hse_pkg::KIND_ADD, 7, 0);
    add_row(hse_pkg::KIND_ADD, 2, 0);
    add_row(hse_pkg::KIND_REPORT, 0, 32768);
    add_row(hse_pkg::KIND_REPORT, 0, 1);
    add_row(hse_pkg::KIND_CLEAR, 1023, 131071);
    add_row(hse_pkg::KIND_ADD, 1023, 0);
    add_row(hse_pkg::KIND_REPORT, 0, 0);
    add_row(hse_pkg::KIND_REPORT, 0, 65535);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_item(rows[i]);

    narrow = 1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 39) == 0) narrow = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      r.typed = 0;
      r.want = '0;
      r.frac = $urandom_range(0, 131071);
      r.value = $urandom_range(0, 1023);
      if (pick < 86) begin
        r.kind = hse_pkg::KIND_ADD;
        if (narrow == 1) r.value = $urandom_range(0, 7);
        else if (narrow == 2) r.value = ($urandom_range(0, 1) != 0) ? 10'd1023 :
                                        $urandom_range(1016, 1023);
      end else if (pick < 94) begin
        r.kind = hse_pkg::KIND_REPORT;
        case ($urandom_range(0, 5))
          0: r.frac = 0;
          1: r.frac = 65535;
          2: r.frac = 65536;
          3, 4: r.frac = $urandom_range(0, 65535);
          default: ;
        endcase
      end else if (pick < 97) begin
        r.kind = hse_pkg::KIND_CLEAR;
      end else begin
        r.kind = KIND_UNUSED;
      end
      send_item(r);
    end
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/hse_pkg.sv
hw/rtl/histogram_stats_engine.sv
test/tb_histogram_stats_engine.sv
